@@ sv/ssds_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssds_pkg
// Constants shared by the sorted stream statistics unit.
// ---------------------------------------------------------------------------
package ssds_pkg;
	localparam int MAX_COUNT  = 4096;
	localparam int ADDR_BITS  = $clog2(MAX_COUNT);
	localparam int CNT_BITS   = ADDR_BITS + 1;
	localparam int VALUE_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int SUM_BITS   = 28;
	localparam int RECIP_SHIFT = 40;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FEW      = 2'd1;
	localparam logic [1:0] ST_UNSORTED = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;
endpackage

@@ sv/sorted_stream_descriptive_stats_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_stream_descriptive_stats_unit
// Statistics over an ascending data set kept in an on-chip value store.
// ---------------------------------------------------------------------------
// Throughput: one request per cycle while loading; busy is low only in the load state.
// After the last request busy stays high through the checks, the store pass with one reciprocal
// division per value, the median and quartile reads, three divisions, the shift-and-add products,
// the square root, an output state and the strobe. An error status skips the arithmetic and goes
// straight to the output state. No stall input.
// Reset clears the state, the load-pass registers, the flags and the status; the store needs no clearing.
module sorted_stream_descriptive_stats_unit
	import ssds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	input  logic        last,
	output logic        result_valid,
	output logic [15:0] min_value,
	output logic [15:0] max_value,
	output logic [15:0] range_value,
	output logic [15:0] mode_value,
	output logic [15:0] median_value,
	output logic [27:0] total_sum,
	output logic [23:0] mean_q8,
	output logic [23:0] harmonic_mean_q8,
	output logic [23:0] std_dev_q8,
	output logic [16:0] iqr_halves,
	output logic [1:0]  status
);
	localparam logic [3:0] S_LOAD  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_RECIP = 4'd2;
	localparam logic [3:0] S_MED   = 4'd3;
	localparam logic [3:0] S_MEAN  = 4'd4;
	localparam logic [3:0] S_HARM  = 4'd5;
	localparam logic [3:0] S_VAR   = 4'd6;
	localparam logic [3:0] S_SQRT  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;
	localparam logic [3:0] S_WAIT  = 4'd9;
	localparam logic [3:0] S_NUM   = 4'd10;

	logic [VALUE_BITS-1:0] mem [MAX_COUNT];
	logic [VALUE_BITS-1:0] rd_s1;

	logic [3:0]          state_q;
	logic [CNT_BITS-1:0] count_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [15:0]         run_val_q, best_val_q;
	logic [CNT_BITS-1:0] run_len_q, best_len_q;
	logic [1:0]          err_q;

	logic [CNT_BITS-1:0] rd_idx_q;
	logic                rd_vld_s1;
	logic [CNT_BITS-1:0] scan_cnt_q;
	logic [15:0]         lo_q, hi_q;
	logic [40:0]         sd_q;
	logic [55:0]         sdd_q;
	logic [63:0]         recip_q;
	logic [2:0]          med_step_q;
	logic [16:0]         a_q, b_q, c_q, d_q, e_q, f_q;

	logic        div_go;
	logic [95:0] div_num;
	logic [63:0] div_den;
	logic        div_done;
	logic [95:0] div_quot;

	logic        rdiv_go_q;
	logic [63:0] rdiv_q;

	logic [95:0]         prod_a_q, prod_b_q, cand_a_q, cand_b_q;
	logic [CNT_BITS-1:0] plier_a_q;
	logic [40:0]         plier_b_q;
	logic [5:0]          mul_cnt_q;

	logic [63:0] sq_x_q, sq_r_q, sq_bit_q;
	logic [23:0] mean_res_q, harm_res_q, sd_res_q;
	logic        go_q;

	logic [CNT_BITS-1:0] n_c, h_c;
	logic                accept;
	logic [16:0]         d_c;

	function automatic logic [23:0] sat24(input logic [95:0] x);
		sat24 = (x > 96'hFFFFFF) ? 24'hFFFFFF : x[23:0];
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != S_LOAD);
	assign n_c    = count_q;
	assign h_c    = count_q >> 1;

	ssds_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Store port: write while loading, read during the passes.
	always_ff @(posedge clk) begin
		if (accept && count_q < CNT_BITS'(MAX_COUNT)) begin
			mem[count_q[ADDR_BITS-1:0]] <= value;
		end
		rd_s1 <= mem[rd_idx_q[ADDR_BITS-1:0]];
	end

	assign d_c = {1'b0, rd_s1} - {1'b0, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			sum_q      <= '0;
			run_val_q  <= '0;
			run_len_q  <= '0;
			best_val_q <= '0;
			best_len_q <= '0;
			err_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rdiv_go_q  <= 1'b0;
			go_q       <= 1'b0;
			result_valid <= 1'b0;
			status     <= ST_OK;
		end else begin
			result_valid <= 1'b0;
			go_q         <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						logic [SUM_BITS:0]   ns;
						logic [CNT_BITS-1:0] rl;
						logic [1:0]          ef;
						ef = err_q;
						ns = {1'b0, sum_q} + (SUM_BITS+1)'(value);
						rl = run_len_q;
						if (count_q < CNT_BITS'(MAX_COUNT)) begin
							if (count_q != '0 && value < run_val_q) ef[0] = 1'b1;
							if (ns[SUM_BITS]) ef[1] = 1'b1;
							sum_q <= ns[SUM_BITS-1:0];
							if (count_q != '0 && value == run_val_q) begin
								rl = run_len_q + 1'b1;
							end else begin
								rl = CNT_BITS'(1);
								run_val_q <= value;
							end
							run_len_q <= rl;
							if (rl > best_len_q) begin
								best_len_q <= rl;
								best_val_q <= (count_q != '0 && value == run_val_q)
									? run_val_q : value;
							end
							count_q <= count_q + 1'b1;
						end else begin
							ef[1] = 1'b1;
						end
						err_q <= ef;
						if (last) begin
							state_q  <= S_SCAN;
							rd_idx_q <= '0;
							scan_cnt_q <= '0;
							sd_q <= '0;
							sdd_q <= '0;
							recip_q <= '0;
							rd_vld_s1 <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					priority if (err_q[1]) begin
						status <= ST_OVERFLOW; state_q <= S_OUT;
					end else if (err_q[0]) begin
						status <= ST_UNSORTED; state_q <= S_OUT;
					end else if (count_q < CNT_BITS'(2)) begin
						status <= ST_FEW; state_q <= S_OUT;
					end else begin
						status <= ST_OK;
						// First read fetches the minimum.
						if (!rd_vld_s1) begin
							rd_vld_s1 <= 1'b1;
							rd_idx_q  <= rd_idx_q + 1'b1;
						end else if (scan_cnt_q == '0) begin
							lo_q <= rd_s1;
							state_q <= S_RECIP;
							rd_idx_q <= '0;
							rd_vld_s1 <= 1'b0;
						end
					end
				end
				S_RECIP: begin
					// One value per divide: reciprocal term floor(2^40/x).
					if (!rd_vld_s1 && !rdiv_go_q && !go_q) begin
						rd_vld_s1 <= 1'b1;
					end else if (rd_vld_s1 && !go_q) begin
						rd_vld_s1 <= 1'b0;
						sd_q  <= sd_q + 41'(d_c);
						sdd_q <= sdd_q + 56'(d_c * d_c);
						if (rd_idx_q == n_c - 1'b1) hi_q <= rd_s1;
						go_q <= 1'b1;
						rdiv_go_q <= 1'b1;
						rdiv_q <= {48'd0, (rd_s1 == '0) ? 16'd1 : rd_s1};
					end else if (div_done) begin
						rdiv_go_q <= 1'b0;
						recip_q <= recip_q + div_quot[63:0];
						if (rd_idx_q == n_c - 1'b1) begin
							state_q <= S_MED;
							med_step_q <= '0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				S_MED: begin
					// Six reads; each index passes the index register and the store output register before capture.
					med_step_q <= med_step_q + 1'b1;
					unique case (med_step_q)
						3'd0: rd_idx_q <= h_c - 1'b1;
						3'd1: rd_idx_q <= h_c;
						3'd2: begin a_q <= {1'b0, rd_s1}; rd_idx_q <= (h_c >> 1) - 1'b1; end
						3'd3: begin b_q <= {1'b0, rd_s1}; rd_idx_q <= h_c >> 1; end
						3'd4: begin c_q <= {1'b0, rd_s1};
							rd_idx_q <= n_c - h_c + (h_c >> 1) - 1'b1; end
						3'd5: begin d_q <= {1'b0, rd_s1};
							rd_idx_q <= n_c - h_c + (h_c >> 1); end
						3'd6: e_q <= {1'b0, rd_s1};
						3'd7: begin
							f_q <= {1'b0, rd_s1};
							state_q <= S_MEAN;
							go_q <= 1'b1;
						end
						default: ;
					endcase
				end
				S_MEAN: if (div_done) begin
					mean_res_q <= sat24(div_quot);
					state_q <= S_HARM; go_q <= 1'b1;
				end
				S_HARM: if (div_done) begin
					harm_res_q <= sat24(div_quot);
					prod_a_q  <= '0;
					prod_b_q  <= '0;
					cand_a_q  <= 96'(sdd_q);
					cand_b_q  <= 96'(sd_q);
					plier_a_q <= n_c;
					plier_b_q <= sd_q;
					mul_cnt_q <= 6'd41;
					state_q <= S_NUM;
				end
				S_NUM: begin
					// Shift and add n*sdd and sd*sd, one multiplier bit per cycle.
					if (mul_cnt_q == '0) begin
						state_q <= S_VAR; go_q <= 1'b1;
					end else begin
						if (plier_a_q[0]) prod_a_q <= prod_a_q + cand_a_q;
						if (plier_b_q[0]) prod_b_q <= prod_b_q + cand_b_q;
						cand_a_q  <= cand_a_q << 1;
						cand_b_q  <= cand_b_q << 1;
						plier_a_q <= plier_a_q >> 1;
						plier_b_q <= plier_b_q >> 1;
						mul_cnt_q <= mul_cnt_q - 6'd1;
					end
				end
				S_VAR: if (div_done) begin
					sq_x_q <= div_quot[63:0];
					sq_r_q <= '0;
					sq_bit_q <= 64'd1 << 62;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (sq_bit_q == '0) begin
						sd_res_q <= sat24({32'd0, sq_r_q});
						state_q <= S_OUT;
					end else begin
						if (sq_x_q >= sq_r_q + sq_bit_q) begin
							sq_x_q <= sq_x_q - (sq_r_q + sq_bit_q);
							sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
						end else begin
							sq_r_q <= sq_r_q >> 1;
						end
						sq_bit_q <= sq_bit_q >> 2;
					end
				end
				S_OUT: begin
					result_valid <= 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_LOAD;
					count_q <= '0; sum_q <= '0; run_val_q <= '0; run_len_q <= '0;
					best_val_q <= '0; best_len_q <= '0; err_q <= '0;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Divider operand selection.
	always_comb begin
		div_go  = go_q;
		div_num = '0;
		div_den = 64'd1;
		unique case (state_q)
			S_RECIP: begin
				div_num = 96'd1 << RECIP_SHIFT;
				div_den = rdiv_q;
			end
			S_MED, S_MEAN: begin
				div_num = 96'(sum_q) << FRAC_BITS;
				div_den = 64'(n_c);
			end
			S_HARM: begin
				div_num = 96'(n_c) << (RECIP_SHIFT + FRAC_BITS);
				div_den = recip_q;
			end
			S_VAR: begin
				div_num = (prod_a_q - prod_b_q) << (2*FRAC_BITS);
				div_den = 64'(n_c) * 64'(n_c - 1'b1);
			end
			default: ;
		endcase
	end

	always_comb begin
		logic ok;
		logic [17:0] q1, q3, md;
		ok = (status == ST_OK);
		md = (n_c[0]) ? {b_q, 1'b0} : 18'(a_q) + 18'(b_q);
		if (h_c[0]) begin
			q1 = {d_q, 1'b0};
			q3 = {f_q, 1'b0};
		end else begin
			q1 = 18'(c_q) + 18'(d_q);
			q3 = 18'(e_q) + 18'(f_q);
		end
		min_value        = ok ? lo_q : '0;
		max_value        = ok ? hi_q : '0;
		range_value      = ok ? hi_q - lo_q : '0;
		mode_value       = ok ? best_val_q : '0;
		median_value     = ok ? md[16:1] : '0;
		total_sum        = ok ? sum_q : '0;
		mean_q8          = ok ? mean_res_q : '0;
		harmonic_mean_q8 = ok ? harm_res_q : '0;
		std_dev_q8       = ok ? sd_res_q : '0;
		iqr_halves       = ok ? 17'(q3 - q1) : '0;
	end
endmodule

@@ sv/ssds_divider.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssds_divider
// Restoring divider, one quotient bit per cycle: q = floor(num / den).
// ---------------------------------------------------------------------------
module ssds_divider
	import ssds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [95:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [95:0] quot
);
	logic [95:0] q_q;
	logic [64:0] r_q;
	logic [63:0] d_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic [64:0] r_sh;

	assign r_sh = {r_q[63:0], q_q[95]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 7'd96;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				q_q <= {q_q[94:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[94:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

@@ sv/ssds_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssds_checker
// Port-level checks of the statistics unit.
// ---------------------------------------------------------------------------
module ssds_checker
	import ssds_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [1:0]  status,
	input logic [15:0] min_value,
	input logic [15:0] max_value,
	input logic [15:0] range_value
);
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe repeated");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result while idle");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_OK) |-> (range_value == max_value - min_value))
		else $error("range mismatch");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |-> (min_value == '0))
		else $error("fields not cleared");
endmodule

bind sorted_stream_descriptive_stats_unit ssds_checker u_ssds_checker (.*);

@@ test/sorted_stream_descriptive_stats_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_stream_descriptive_stats_unit_tb
// Streams data sets into the statistics unit, predicts every result in the
// bench and checks each result field against the prediction.
// ---------------------------------------------------------------------------
module sorted_stream_descriptive_stats_unit_tb;
	import ssds_pkg::*;

	typedef struct packed {
		logic [15:0] min_v;
		logic [15:0] max_v;
		logic [15:0] range_v;
		logic [15:0] mode_v;
		logic [15:0] median_v;
		logic [27:0] sum_v;
		logic [23:0] mean_v;
		logic [23:0] hmean_v;
		logic [23:0] sdev_v;
		logic [16:0] iqr_v;
		logic [1:0]  stat_v;
	} stats_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] value;
	logic        last;
	logic        result_valid;
	logic [15:0] min_value, max_value, range_value, mode_value, median_value;
	logic [27:0] total_sum;
	logic [23:0] mean_q8, harmonic_mean_q8, std_dev_q8;
	logic [16:0] iqr_halves;
	logic [1:0]  status;

	sorted_stream_descriptive_stats_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.value(value), .last(last), .result_valid(result_valid),
		.min_value(min_value), .max_value(max_value), .range_value(range_value),
		.mode_value(mode_value), .median_value(median_value), .total_sum(total_sum),
		.mean_q8(mean_q8), .harmonic_mean_q8(harmonic_mean_q8),
		.std_dev_q8(std_dev_q8), .iqr_halves(iqr_halves), .status(status)
	);

	// Bench copy of the block state.
	logic [15:0] set_store [0:MAX_COUNT-1];
	int unsigned set_count;
	longint unsigned set_sum;
	logic [15:0] cur_run_value, top_run_value;
	int unsigned cur_run_len, top_run_len;
	bit          unsorted_seen, overflow_seen;

	stats_t      pending_stats [$];
	int unsigned fail_count;
	int unsigned random_items;
	bit          no_gaps;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint unsigned frac_divide(longint unsigned num,
			longint unsigned den, int bits);
		longint unsigned q, r;
		q = num / den;
		r = num % den;
		for (int i = 0; i < bits; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sat24(longint unsigned x);
		return (x > 64'hFFFFFF) ? 64'hFFFFFF : x;
	endfunction

	// Twice the median of len stored values starting at first.
	function automatic longint unsigned twice_median(int unsigned first, int unsigned len);
		int unsigned h;
		h = len / 2;
		if (len % 2 == 0)
			return longint'(set_store[first + h - 1]) + longint'(set_store[first + h]);
		return 2 * longint'(set_store[first + h]);
	endfunction

	function automatic void clear_set();
		set_count = 0;
		set_sum = 0;
		cur_run_value = '0;
		cur_run_len = 0;
		top_run_value = '0;
		top_run_len = 0;
		unsorted_seen = 0;
		overflow_seen = 0;
	endfunction

	function automatic void absorb_value(logic [15:0] v, logic is_last);
		stats_t s;
		int unsigned n, h;
		longint unsigned lo, hi, d, sd, sdd, recip, num, var_q;
		if (set_count < MAX_COUNT) begin
			if (set_count > 0 && v < cur_run_value) unsorted_seen = 1;
			if (set_sum + v > 64'h0FFF_FFFF) overflow_seen = 1;
			set_sum = (set_sum + v) & 64'h0FFF_FFFF;
			set_store[set_count] = v;
			if (set_count > 0 && v == cur_run_value)
				cur_run_len++;
			else begin
				cur_run_value = v;
				cur_run_len = 1;
			end
			if (cur_run_len > top_run_len) begin
				top_run_len = cur_run_len;
				top_run_value = cur_run_value;
			end
			set_count++;
		end else
			overflow_seen = 1;
		if (!is_last) return;
		s = '0;
		n = set_count;
		if (overflow_seen) s.stat_v = ST_OVERFLOW;
		else if (unsorted_seen) s.stat_v = ST_UNSORTED;
		else if (n < 2) s.stat_v = ST_FEW;
		else s.stat_v = ST_OK;
		if (s.stat_v == ST_OK) begin
			lo = set_store[0];
			hi = set_store[n - 1];
			sd = 0;
			sdd = 0;
			recip = 0;
			for (int i = 0; i < n; i++) begin
				d = set_store[i] - lo;
				sd += d;
				sdd += d * d;
				recip += (64'd1 << RECIP_SHIFT) / ((set_store[i] != 0) ? set_store[i] : 1);
			end
			num = longint'(n) * sdd - sd * sd;
			var_q = frac_divide(num, longint'(n) * (n - 1), 2 * FRAC_BITS);
			h = n / 2;
			s.min_v = lo;
			s.max_v = hi;
			s.range_v = hi - lo;
			s.mode_v = top_run_value;
			s.median_v = twice_median(0, n) / 2;
			s.sum_v = set_sum;
			s.mean_v = sat24(frac_divide(set_sum, n, FRAC_BITS));
			s.hmean_v = sat24(frac_divide(longint'(n) << RECIP_SHIFT, recip, FRAC_BITS));
			s.sdev_v = sat24(int_sqrt(var_q));
			s.iqr_v = twice_median(n - h, h) - twice_median(0, h);
		end
		pending_stats.push_back(s);
		clear_set();
	endfunction

	task automatic compare_field(string field, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		stats_t e;
		if (arst_n && result_valid) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %0d",
					$realtime, status);
				fail_count++;
			end else begin
				e = pending_stats.pop_front();
				compare_field("min_value", e.min_v, min_value);
				compare_field("max_value", e.max_v, max_value);
				compare_field("range_value", e.range_v, range_value);
				compare_field("mode_value", e.mode_v, mode_value);
				compare_field("median_value", e.median_v, median_value);
				compare_field("total_sum", e.sum_v, total_sum);
				compare_field("mean_q8", e.mean_v, mean_q8);
				compare_field("harmonic_mean_q8", e.hmean_v, harmonic_mean_q8);
				compare_field("std_dev_q8", e.sdev_v, std_dev_q8);
				compare_field("iqr_halves", e.iqr_v, iqr_halves);
				compare_field("status", e.stat_v, status);
			end
		end
	end

	// Sends one request and returns right after the edge that accepts it.
	task automatic send_value(logic [15:0] v, logic is_last);
		if (!no_gaps && $urandom_range(99) < 27) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		last <= is_last;
		// busy only changes on rising edges, so it is stable at the falling edge.
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		@(posedge clk);
		absorb_value(v, is_last);
	endtask

	task automatic send_set(logic [15:0] vals [$]);
		foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
	endtask

	task automatic test_extremes();
		send_set('{16'd1, 16'd65535});
		send_set('{16'd65535, 16'd65535});
		send_set('{16'd1, 16'd1, 16'd2, 16'd3, 16'd65535});
		send_set('{16'd0, 16'd7});
	endtask

	task automatic test_mode_ties();
		send_set('{16'd3, 16'd3, 16'd8, 16'd8, 16'd9, 16'd12});
		send_set('{16'd10, 16'd20, 16'd20, 16'd20});
	endtask

	task automatic test_status_cases();
		send_set('{16'd500});
		send_set('{16'd9, 16'd4, 16'd5});
	endtask

	task automatic test_random();
		logic [15:0] vals [$];
		int unsigned len, cur, kind;
		random_items = 0;
		no_gaps = 1;
		while (random_items < 950) begin
			if (random_items > 300) no_gaps = 0;
			vals.delete();
			len = ($urandom_range(19) == 0) ? $urandom_range(200, 40) : $urandom_range(24, 1);
			kind = $urandom_range(9);
			cur = (kind < 3) ? $urandom_range(65535 - 4 * len, 1) : $urandom_range(300, 1);
			for (int i = 0; i < len; i++) begin
				vals.push_back(16'(cur));
				if ($urandom_range(2) != 0)
					cur = cur + ((kind == 0) ? $urandom_range(4) : $urandom_range(40));
				if (cur > 65535) cur = 65535;
			end
			// Some sets may carry a descending step.
			if (kind == 9 && len > 1) vals[$urandom_range(len - 1, 1)] = 16'($urandom_range(65535));
			if (kind == 8) vals[len - 1] = 16'($urandom_range(65535, 32768));
			send_set(vals);
			random_items += len;
		end
	endtask

	initial begin
		clear_set();
		fail_count = 0;
		no_gaps = 0;
		start <= 1'b0;
		value <= '0;
		last <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_mode_ties();
		test_status_cases();
		test_random();
		start <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

@@ files.f @@
sv/ssds_pkg.sv
sv/ssds_divider.sv
sv/sorted_stream_descriptive_stats_unit.sv
sv/ssds_checker.sv
test/sorted_stream_descriptive_stats_unit_tb.sv
